>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication: when ante holds, cons must hold on that edge.
`define SFM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");
// Next-cycle implication: when ante holds, cons must hold on the following edge.
`define SFM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");
`else
`define SFM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SFM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/sfm_pkg.sv
package sfm_pkg;

    localparam int SET_DEPTH_DEF  = 16;
    localparam int VALUE_BITS_DEF = 16;

    typedef enum logic [1:0] {
        S_LOAD,
        S_SETTLE,
        S_SCAN,
        S_EMIT
    } t_state;

    // What every cell of the chain does in a cycle.
    typedef enum logic [0:0] {
        CELL_INSERT,
        CELL_MOVE
    } t_cell_op;

    typedef struct packed {
        logic clear;
        logic smp_vld;
    } t_mode_ctl;

endpackage

>>> rtl/sort_and_find_mode.sv
// Channel  Direction  Handshake                      Payload
// in       input      i_in_valid / o_in_ready        i_sample_value, i_set_end
// out      output     o_out_valid / i_out_ready      o_sorted_value, o_mode_value, o_run_end
//
// Loading takes one cycle per word while the block is in its load phase.
// After the word marked as set end, the insertion wave settles in the cell
// chain and the mode scan then rotates the chain once. Emission gives one
// word per cycle while the output is ready, and the block returns to loading
// once the chain has drained. Reset (synchronous, active low) empties every
// cell; a stall on the output simply holds the chain.
`include "assert_macros.svh"

module sort_and_find_mode
    import sfm_pkg::*;
#(
    parameter int SET_DEPTH  = SET_DEPTH_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [VALUE_BITS-1:0] i_sample_value,
    input  logic                  i_set_end,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [VALUE_BITS-1:0] o_sorted_value,
    output logic [VALUE_BITS-1:0] o_mode_value,
    output logic                  o_run_end
);

    localparam int FW = $clog2(SET_DEPTH + 1);
    localparam int CW = $clog2(SET_DEPTH);
    localparam logic [FW-1:0] FILL_MAX = FW'(SET_DEPTH);
    localparam logic [CW-1:0] CNT_LAST = CW'(SET_DEPTH - 1);

    t_state        r_state, n_state;
    logic [FW-1:0] r_fill, n_fill;
    logic [CW-1:0] r_cnt, n_cnt;

    // Chain wiring: every cell exposes its value, its full flag and the word
    // it passes down the chain during insertion.
    logic [VALUE_BITS-1:0] w_val      [SET_DEPTH];
    logic [SET_DEPTH-1:0]  w_full;
    logic [VALUE_BITS-1:0] w_pass_val [SET_DEPTH];
    logic [SET_DEPTH-1:0]  w_pass_vld;

    t_cell_op  w_op;
    t_mode_ctl w_mode_ctl;
    logic      w_in_acc;
    logic      w_out_acc;
    logic      w_store;

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_out_acc = o_out_valid && i_out_ready;
    // A word that arrives with the store full is dropped, but its set-end
    // flag still counts.
    assign w_store   = w_in_acc && (r_fill < FILL_MAX);

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_LOAD: begin
                if (w_store) begin
                    n_fill = r_fill + FW'(1);
                end
                if (w_in_acc && i_set_end) begin
                    n_state = S_SETTLE;
                    n_cnt   = '0;
                end
            end
            S_SETTLE: begin
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CNT_LAST) begin
                    n_state = S_SCAN;
                    n_cnt   = '0;
                end
            end
            S_SCAN: begin
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CNT_LAST) begin
                    n_state = S_EMIT;
                    n_cnt   = '0;
                end
            end
            S_EMIT: begin
                // The chain has drained once its front cell is empty.
                if (!w_full[0]) begin
                    n_state = S_LOAD;
                    n_fill  = '0;
                end
            end
        endcase
    end

    // Output and chain control logic.
    always_comb begin
        o_in_ready         = 1'b0;
        o_out_valid        = 1'b0;
        w_op               = CELL_INSERT;
        w_mode_ctl.clear   = 1'b0;
        w_mode_ctl.smp_vld = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
            end
            S_SETTLE: begin
                w_mode_ctl.clear = 1'b1;
            end
            S_SCAN: begin
                // Rotating the whole chain once shows every cell at the front
                // in ascending order and leaves the chain as it was.
                w_op               = CELL_MOVE;
                w_mode_ctl.smp_vld = w_full[0];
            end
            S_EMIT: begin
                o_out_valid = w_full[0];
                w_op        = w_out_acc ? CELL_MOVE : CELL_INSERT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_fill  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_cnt   <= n_cnt;
        end
    end

    genvar k;
    generate
        for (k = 0; k < SET_DEPTH; k++) begin : g_cell
            logic [VALUE_BITS-1:0] w_ins_val;
            logic                  w_ins_vld;
            logic [VALUE_BITS-1:0] w_nxt_val;
            logic                  w_nxt_full;

            if (k == 0) begin : g_head
                assign w_ins_val = i_sample_value;
                assign w_ins_vld = w_store;
            end else begin : g_body
                assign w_ins_val = w_pass_val[k-1];
                assign w_ins_vld = w_pass_vld[k-1];
            end

            // The tail closes the ring during the scan and feeds empty
            // cells in while the sorted words are shifted out.
            if (k == SET_DEPTH - 1) begin : g_tail
                assign w_nxt_val  = w_val[0];
                assign w_nxt_full = (r_state == S_SCAN) ? w_full[0] : 1'b0;
            end else begin : g_link
                assign w_nxt_val  = w_val[k+1];
                assign w_nxt_full = w_full[k+1];
            end

            sfm_cell #(
                .VALUE_BITS (VALUE_BITS)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_op       (w_op),
                .i_ins_val  (w_ins_val),
                .i_ins_vld  (w_ins_vld),
                .i_nxt_val  (w_nxt_val),
                .i_nxt_full (w_nxt_full),
                .o_val      (w_val[k]),
                .o_full     (w_full[k]),
                .o_pass_val (w_pass_val[k]),
                .o_pass_vld (w_pass_vld[k])
            );
        end
    endgenerate

    sfm_mode #(
        .SET_DEPTH  (SET_DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_mode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_mode_ctl),
        .i_smp_val (w_val[0]),
        .o_mode    (o_mode_value)
    );

    // The front cell is the output register; the final word is the one with
    // nothing behind it.
    assign o_sorted_value = w_val[0];
    assign o_run_end      = !w_full[1];

    `SFM_ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FILL_MAX)
    `SFM_ASSERT_NOW(a_settled, i_clk, i_rst_n, r_state == S_SCAN, w_pass_vld == '0)
    `SFM_ASSERT_NOW(a_ascending, i_clk, i_rst_n, o_out_valid && !o_run_end, w_val[0] <= w_val[1])
    `SFM_ASSERT_NEXT(a_drained, i_clk, i_rst_n, r_state == S_EMIT && !w_full[0], w_full == '0)

endmodule

>>> rtl/sfm_cell.sv
module sfm_cell
    import sfm_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_op              i_op,
    input  logic [VALUE_BITS-1:0] i_ins_val,
    input  logic                  i_ins_vld,
    input  logic [VALUE_BITS-1:0] i_nxt_val,
    input  logic                  i_nxt_full,
    output logic [VALUE_BITS-1:0] o_val,
    output logic                  o_full,
    output logic [VALUE_BITS-1:0] o_pass_val,
    output logic                  o_pass_vld
);

    logic [VALUE_BITS-1:0] r_val, n_val;
    logic                  r_full, n_full;
    logic [VALUE_BITS-1:0] r_pass_val, n_pass_val;
    logic                  r_pass_vld, n_pass_vld;

    // The cell keeps the smaller of its value and the arriving one and hands
    // the larger on, so the chain stays sorted ascending from the front.
    always_comb begin
        n_val      = r_val;
        n_full     = r_full;
        n_pass_val = r_pass_val;
        n_pass_vld = 1'b0;
        unique case (i_op)
            CELL_INSERT: begin
                if (i_ins_vld) begin
                    if (!r_full) begin
                        n_val  = i_ins_val;
                        n_full = 1'b1;
                    end else if (i_ins_val < r_val) begin
                        n_val      = i_ins_val;
                        n_pass_val = r_val;
                        n_pass_vld = 1'b1;
                    end else begin
                        n_pass_val = i_ins_val;
                        n_pass_vld = 1'b1;
                    end
                end
            end
            CELL_MOVE: begin
                n_val  = i_nxt_val;
                n_full = i_nxt_full;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full     <= 1'b0;
            r_pass_vld <= 1'b0;
        end else begin
            r_full     <= n_full;
            r_pass_vld <= n_pass_vld;
        end
        r_val      <= n_val;
        r_pass_val <= n_pass_val;
    end

    assign o_val      = r_val;
    assign o_full     = r_full;
    assign o_pass_val = r_pass_val;
    assign o_pass_vld = r_pass_vld;

endmodule

>>> rtl/sfm_mode.sv
module sfm_mode
    import sfm_pkg::*;
#(
    parameter int SET_DEPTH  = SET_DEPTH_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_mode_ctl             i_ctl,
    input  logic [VALUE_BITS-1:0] i_smp_val,
    output logic [VALUE_BITS-1:0] o_mode
);

    localparam int LW = $clog2(SET_DEPTH + 1);

    logic                  r_seen, n_seen;
    logic [VALUE_BITS-1:0] r_grp_val, n_grp_val;
    logic [LW-1:0]         r_grp_len, n_grp_len;
    logic [VALUE_BITS-1:0] r_best_val, n_best_val;
    logic [LW-1:0]         r_best_len, n_best_len;

    // Run-length tracking over a sorted stream; a strict compare keeps the
    // smaller value when two runs are equally long.
    always_comb begin
        n_seen     = r_seen;
        n_grp_val  = r_grp_val;
        n_grp_len  = r_grp_len;
        n_best_val = r_best_val;
        n_best_len = r_best_len;
        if (i_ctl.clear) begin
            n_seen = 1'b0;
        end else if (i_ctl.smp_vld) begin
            if (!r_seen) begin
                n_seen     = 1'b1;
                n_grp_val  = i_smp_val;
                n_grp_len  = LW'(1);
                n_best_val = i_smp_val;
                n_best_len = LW'(1);
            end else if (i_smp_val == r_grp_val) begin
                n_grp_len = r_grp_len + LW'(1);
            end else begin
                if (r_grp_len > r_best_len) begin
                    n_best_val = r_grp_val;
                    n_best_len = r_grp_len;
                end
                n_grp_val = i_smp_val;
                n_grp_len = LW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else begin
            r_seen <= n_seen;
        end
        r_grp_val  <= n_grp_val;
        r_grp_len  <= n_grp_len;
        r_best_val <= n_best_val;
        r_best_len <= n_best_len;
    end

    // The run still open at the end of the scan gets its final comparison here.
    assign o_mode = (r_grp_len > r_best_len) ? r_grp_val : r_best_val;

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import sfm_pkg::*;

    localparam int DEPTH = SET_DEPTH_DEF;
    localparam int BITS  = VALUE_BITS_DEF;

    // Cycles the block spends on a set after its last word, with some
    // margin on top.
    localparam int SET_TAIL_CYCLES = 3 * DEPTH + 8;

    // Idling odds in percent. The calm windows below switch idling off.
    localparam int IDLE_PERCENT = 37;

    // One word offered on the input channel.
    typedef struct {
        logic [BITS-1:0] sample;
        logic            last;
    } t_load_word;

    // One word expected on the output channel.
    typedef struct {
        logic [BITS-1:0] sorted;
        logic [BITS-1:0] mode;
        logic            last;
    } t_sorted_word;

    logic            i_clk          = 1'b0;
    logic            i_rst_n        = 1'b0;
    logic            i_in_valid     = 1'b0;
    logic            o_in_ready;
    logic [BITS-1:0] i_sample_value = '0;
    logic            i_set_end      = 1'b0;
    logic            o_out_valid;
    logic            i_out_ready    = 1'b0;
    logic [BITS-1:0] o_sorted_value;
    logic [BITS-1:0] o_mode_value;
    logic            o_run_end;

    // Words waiting to be offered, and sorted words waiting to come out.
    t_load_word   load_words[$];
    t_sorted_word sorted_words_due[$];

    // The predictor's own copy of the block's store and its fill level.
    logic [BITS-1:0] shelf [DEPTH];
    int              shelf_fill = 0;

    int  error_count  = 0;
    int  words_sent   = 0;
    int  words_taken  = 0;
    bit  in_fire      = 1'b0;

    sort_and_find_mode #(
        .SET_DEPTH  (DEPTH),
        .VALUE_BITS (BITS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample_value (i_sample_value),
        .i_set_end      (i_set_end),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_sorted_value (o_sorted_value),
        .o_mode_value   (o_mode_value),
        .o_run_end      (o_run_end)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Appends one word to the list of pending input words.
    task automatic queue_word(input logic [BITS-1:0] sample, input logic last);
        t_load_word w;
        w.sample = sample;
        w.last   = last;
        load_words.push_back(w);
    endtask

    // Takes in one accepted input word. Words beyond the store's capacity
    // are dropped, but a dropped word marked last still closes the set. On
    // the last word the stored values are put in ascending order, the most
    // frequent value is found (a tie goes to the smallest, which comes first
    // in sorted order), and one output word per stored value is expected.
    task automatic take_load_word(input logic [BITS-1:0] sample, input logic last);
        logic [BITS-1:0] ordered [DEPTH];
        logic [BITS-1:0] held;
        logic [BITS-1:0] run_val;
        logic [BITS-1:0] top_val;
        int              run_len;
        int              top_len;
        t_sorted_word    w;
        if (shelf_fill < DEPTH) begin
            shelf[shelf_fill] = sample;
            shelf_fill++;
        end
        if (last) begin
            for (int k = 0; k < shelf_fill; k++) begin
                ordered[k] = shelf[k];
            end
            for (int pass = 0; pass + 1 < shelf_fill; pass++) begin
                for (int k = 0; k + 1 < shelf_fill - pass; k++) begin
                    if (ordered[k] > ordered[k+1]) begin
                        held         = ordered[k];
                        ordered[k]   = ordered[k+1];
                        ordered[k+1] = held;
                    end
                end
            end
            // Run-length scan over the sorted values. Only a strictly longer
            // run displaces the current best, so ties keep the smaller value.
            run_val = ordered[0];
            top_val = ordered[0];
            run_len = 1;
            top_len = 1;
            for (int k = 1; k < shelf_fill; k++) begin
                if (ordered[k] == run_val) begin
                    run_len++;
                end else begin
                    if (run_len > top_len) begin
                        top_len = run_len;
                        top_val = run_val;
                    end
                    run_val = ordered[k];
                    run_len = 1;
                end
            end
            if (run_len > top_len) begin
                top_val = run_val;
            end
            for (int k = 0; k < shelf_fill; k++) begin
                w.sorted = ordered[k];
                w.mode   = top_val;
                w.last   = (k + 1 == shelf_fill);
                sorted_words_due.push_back(w);
            end
            shelf_fill = 0;
        end
    endtask

    // Input driver. Everything changes at the falling edge. A new word is
    // only put up once the previous one has been taken (or none was up), so
    // valid and the payload hold steady while the block is not ready. For a
    // stretch of words in the middle of the run the driver never idles.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            if (load_words.size() != 0 &&
                ((words_sent >= 120 && words_sent < 170) ||
                 $urandom_range(0, 99) >= IDLE_PERCENT)) begin
                i_sample_value <= load_words[0].sample;
                i_set_end      <= load_words[0].last;
                i_in_valid     <= 1'b1;
                void'(load_words.pop_front());
                words_sent++;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output back-pressure, with its own calm stretch partway through.
    always @(negedge i_clk) begin
        if (words_taken >= 90 && words_taken < 150) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Monitor. Both channels are sampled at the rising edge. An accepted
    // input word goes to the predictor; an accepted output word is checked
    // field by field against the oldest expected word.
    always @(posedge i_clk) begin
        in_fire <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                take_load_word(i_sample_value, i_set_end);
            end
            if (o_out_valid && i_out_ready) begin
                words_taken++;
                if (sorted_words_due.size() == 0) begin
                    $error("unexpected output word: sorted_value %0h mode_value %0h run_end %0b",
                           o_sorted_value, o_mode_value, o_run_end);
                    error_count++;
                end else begin
                    if (o_sorted_value !== sorted_words_due[0].sorted) begin
                        $error("sorted_value: expected %0h, actual %0h",
                               sorted_words_due[0].sorted, o_sorted_value);
                        error_count++;
                    end
                    if (o_mode_value !== sorted_words_due[0].mode) begin
                        $error("mode_value: expected %0h, actual %0h",
                               sorted_words_due[0].mode, o_mode_value);
                        error_count++;
                    end
                    if (o_run_end !== sorted_words_due[0].last) begin
                        $error("run_end: expected %0b, actual %0b",
                               sorted_words_due[0].last, o_run_end);
                        error_count++;
                    end
                    void'(sorted_words_due.pop_front());
                end
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int set_len;
        int flavour;
        int random_words;
        logic [BITS-1:0] sample;

        // Directed sets. A set of one value at each end of the range.
        queue_word('0, 1'b1);
        queue_word('1, 1'b1);
        // Two values tie for most frequent; the smaller must be reported.
        queue_word(16'd9, 1'b0);
        queue_word(16'd2, 1'b0);
        queue_word(16'd9, 1'b0);
        queue_word(16'd2, 1'b0);
        queue_word('1, 1'b1);
        // A full store in descending order, then a last word that finds the
        // store full: it is dropped but still starts the sort.
        queue_word('1, 1'b0);
        for (int k = 1; k < DEPTH; k++) begin
            queue_word(BITS'((DEPTH - 1 - k) * 16'h1111), 1'b0);
        end
        queue_word(16'h1234, 1'b1);

        // Random sets. Most fit the store; some overflow it. Values come
        // either from a tiny range, so that repeats and ties are common, or
        // from the whole range.
        random_words = 0;
        while (random_words < 196) begin
            if ($urandom_range(0, 7) == 0) begin
                set_len = $urandom_range(DEPTH + 1, DEPTH + 6);
            end else begin
                set_len = $urandom_range(1, DEPTH);
            end
            flavour = $urandom_range(0, 2);
            for (int k = 0; k < set_len; k++) begin
                if (flavour == 0) begin
                    sample = BITS'($urandom_range(0, 3));
                end else if ($urandom_range(0, 15) == 0) begin
                    sample = $urandom_range(0, 1) ? '1 : '0;
                end else begin
                    sample = BITS'($urandom_range(0, 65535));
                end
                queue_word(sample, k + 1 == set_len);
            end
            random_words += set_len;
        end

        // Hold reset, then release it at a falling edge.
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every word has been offered and taken, then until every
        // expected word has come out, then a little longer to catch strays.
        while (load_words.size() != 0 || i_in_valid) @(negedge i_clk);
        while (sorted_words_due.size() != 0) @(negedge i_clk);
        repeat (SET_TAIL_CYCLES) @(negedge i_clk);

        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/sfm_pkg.sv
rtl/sfm_cell.sv
rtl/sfm_mode.sv
rtl/sort_and_find_mode.sv
dv/testbench.sv
